>>> rtl/hwc_pkg.sv
package hwc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned MixRows = 9;
  localparam int unsigned RowIdxW = $clog2(MixRows);

  localparam logic [WordW-1:0] Golden = 32'h9e3779b9;

  typedef enum logic [1:0] {
    ROW_X,
    ROW_G,
    ROW_Y
  } row_kind_e;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] g;
    logic [WordW-1:0] y;
  } mix_t;

  typedef struct packed {
    logic cmd;
    mix_t a;
    mix_t b;
  } pipe_t;

  localparam row_kind_e RowKind [MixRows] = '{
    ROW_X, ROW_G, ROW_Y,
    ROW_X, ROW_G, ROW_Y,
    ROW_X, ROW_G, ROW_Y
  };

  localparam logic [4:0] RowShift [MixRows] = '{
    5'd13, 5'd8, 5'd13,
    5'd12, 5'd16, 5'd5,
    5'd3, 5'd10, 5'd15
  };

  function automatic mix_t mix_init(logic [WordW-1:0] x, logic [WordW-1:0] y);
    mix_t s;
    s.x = x;
    s.g = Golden;
    s.y = y;
    return s;
  endfunction

  // one line of the lookup2 mix; the very first line drops g as the leading
  // add and subtract of the golden word cancel
  function automatic mix_t row_op(mix_t s, logic [RowIdxW-1:0] line);
    mix_t             r;
    logic [WordW-1:0] gx;
    logic [4:0]       sh;
    r  = s;
    sh = RowShift[line];
    gx = (line == '0) ? '0 : s.g;
    case (RowKind[line])
      ROW_X: r.x = (s.x - gx - s.y) ^ (s.y >> sh);
      ROW_G: r.g = (s.g - s.y - s.x) ^ (s.x << sh);
      default: r.y = (s.y - s.x - s.g) ^ (s.g >> sh);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hwc_stage.sv
module hwc_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hwc_pkg::RowIdxW-1:0] line_i,
  input  logic                        b_en_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  hwc_pkg::pipe_t              data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output hwc_pkg::pipe_t              data_o
);
  import hwc_pkg::*;

  logic  valid_q, valid_d;
  pipe_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d    = ready_o ? valid_i : valid_q;
    data_d.cmd = data_i.cmd;
    data_d.a   = row_op(data_i.a, line_i);
    // lane b holds its word unchanged when disabled
    data_d.b   = b_en_i ? row_op(data_i.b, line_i) : data_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/hwc_mix.sv
module hwc_mix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           b_en_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  hwc_pkg::pipe_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hwc_pkg::pipe_t data_o
);
  import hwc_pkg::*;

  logic  vld [MixRows+1];
  logic  rdy [MixRows+1];
  pipe_t dat [MixRows+1];

  assign vld[0]       = valid_i;
  assign dat[0]       = data_i;
  assign ready_o      = rdy[0];
  assign rdy[MixRows] = ready_i;

  for (genvar i = 0; i < MixRows; i++) begin : g_row
    hwc_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .line_i  (RowIdxW'(i)),
      .b_en_i  (b_en_i),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (dat[i+1])
    );
  end

  assign valid_o = vld[MixRows];
  assign data_o  = dat[MixRows];

endmodule

>>> rtl/hash_word_combine_top.sv
// Hash combiner on the lookup2 mix: cmd 0 mixes in_w0,in_w1; cmd 1 mixes
// (in_w0,in_w1) and (in_w2,in_w3) side by side and then mixes the two
// results. One beat is taken every cycle while nothing stalls; each result
// passes nine mix lines per pass, one register stage per line, two passes
// in series; pair beats travel the same path so results stay in order.
// Stages only halt when their successor is full, and in_ready_o follows
// out_ready_i combinationally through the full stages.
module hash_word_combine_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [hwc_pkg::WordW-1:0] in_w0_i,
  input  logic [hwc_pkg::WordW-1:0] in_w1_i,
  input  logic [hwc_pkg::WordW-1:0] in_w2_i,
  input  logic [hwc_pkg::WordW-1:0] in_w3_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [hwc_pkg::WordW-1:0] hash_out_o
);
  import hwc_pkg::*;

  pipe_t in_data;
  pipe_t mid_data;
  pipe_t mid_next;
  pipe_t fin_data;
  logic  mid_valid;
  logic  mid_ready;

  always_comb begin
    in_data.cmd = cmd_i;
    in_data.a   = mix_init(in_w0_i, in_w1_i);
    in_data.b   = mix_init(in_w2_i, in_w3_i);
  end

  hwc_mix u_mix_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .b_en_i  (1'b1),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  // second pass mixes the two pair results; lane b parks the pair result
  always_comb begin
    mid_next.cmd = mid_data.cmd;
    mid_next.a   = mix_init(mid_data.a.y, mid_data.b.y);
    mid_next.b   = mix_init(mid_data.a.y, mid_data.a.y);
  end

  hwc_mix u_mix_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .b_en_i  (1'b0),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_next),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (fin_data)
  );

  assign hash_out_o = fin_data.cmd ? fin_data.a.y : fin_data.b.y;

`ifndef SYNTH
  // back pressure is the only reason to refuse a beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back pressure");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_data)))
    else $error("mid-pipe beat changed while stalled");

  a_mid_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mid_ready |-> (out_valid_o && !out_ready_i))
    else $error("second pass stalled without output back pressure");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (!out_valid_o && !mid_valid))
    else $error("pipe not empty after reset");
`endif

endmodule
